/* rtl/core/bilinear_image_resize_16bit_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear resize core
// Concurrent checks sampled on clk, masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESIZE_16BIT_CORE_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_16BIT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge
`define BIR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BIR_ASSERT(lbl, cond, msg)
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/bir_pkg.sv */
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear resize core.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_SIDE_DEF   = 256;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int CFG_BITS       = 9;
  localparam int CFG_IDX_BITS   = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int FRAC_BITS      = 16;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 4'd0,
    REG_SOURCE_HEIGHT = 4'd1,
    REG_TARGET_WIDTH  = 4'd2,
    REG_TARGET_HEIGHT = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        last_pixel;
  } out_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV_X,
    BK_DIV_Y,
    BK_POS,
    BK_GEO,
    BK_READ,
    BK_MUL,
    BK_ACC,
    BK_DONE
  } back_state_t;

endpackage

/* rtl/core/bir_front.sv */
// ----------------------------------------------------------------------------
// bir_front
// Accepts items, assigns load addresses and destination coordinates.
// ----------------------------------------------------------------------------
module bir_front
  import bir_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1,
  localparam int AW = 2 * CW,
  localparam int QW = 2 + PIXEL_BITS + AW + 2 * CW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_item,
  input  logic [SW-1:0] src_w,
  input  logic [SW-1:0] src_h,
  input  logic [SW-1:0] dst_w,
  input  logic [SW-1:0] dst_h,
  input  q_status_t     q_stat,
  output logic          push,
  output logic [QW-1:0] push_data
);

  typedef struct packed {
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel;
    logic [AW-1:0]         addr;
    logic [CW-1:0]         col;
    logic [CW-1:0]         row;
    logic                  last;
  } job_t;

  localparam int TW = 2 * SW;

  logic [AW-1:0] load_pos, load_pos_next;
  logic [CW-1:0] col, col_next, row, row_next;
  logic [TW-1:0] total, lp_cur, lp_inc;
  logic [SW-1:0] c0, r0, c1, r1;
  logic          accept;
  job_t          job;

  assign accept   = in_valid && !q_stat.full;
  assign in_stall = q_stat.full;
  assign push     = accept;
  assign push_data = job;

  // load address and wrap at the end of the source frame
  always_comb begin
    total  = TW'(src_w * src_h);
    lp_cur = (TW'(load_pos) >= total) ? '0 : TW'(load_pos);
    lp_inc = lp_cur + TW'(1);
    load_pos_next = (lp_inc >= total) ? '0 : lp_inc[AW-1:0];
  end

  // destination coordinates, restarted when out of range
  always_comb begin
    c0 = SW'(col);
    r0 = SW'(row);
    if (c0 >= dst_w || r0 >= dst_h) begin
      c0 = '0;
      r0 = '0;
    end
    c1 = c0 + SW'(1);
    r1 = r0;
    if (c1 >= dst_w) begin
      c1 = '0;
      r1 = r0 + SW'(1);
      if (r1 >= dst_h) begin
        r1 = '0;
      end
    end
    col_next = c1[CW-1:0];
    row_next = r1[CW-1:0];
  end

  // job packing
  always_comb begin
    job.kind  = in_item.kind;
    job.pixel = in_item.pixel_in[PIXEL_BITS-1:0];
    job.addr  = lp_cur[AW-1:0];
    job.col   = c0[CW-1:0];
    job.row   = r0[CW-1:0];
    job.last  = (r0 == dst_h - SW'(1)) && (c0 == dst_w - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      col      <= '0;
      row      <= '0;
    end else if (accept) begin
      if (in_item.kind == KIND_LOAD) begin
        load_pos <= load_pos_next;
      end else begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

endmodule

/* rtl/core/bir_queue.sv */
// ----------------------------------------------------------------------------
// bir_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "bilinear_image_resize_16bit_core_assert.svh"
module bir_queue
  import bir_pkg::*;
#(
  parameter int QW    = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  input  logic          pop,
  output logic [QW-1:0] pop_data,
  output q_status_t     q_stat
);

  logic [QW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign q_stat.full  = (count == NW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  `BIR_ASSERT(a_no_overflow, !(push && q_stat.full), "push into full queue")
  `BIR_ASSERT(a_no_underflow, !(pop && q_stat.empty), "pop from empty queue")
  `BIR_ASSERT_NEXT(a_fill_up, push && !pop, count == $past(count) + NW'(1), "fill level lost")

endmodule

/* rtl/core/bir_back.sv */
// ----------------------------------------------------------------------------
// bir_back
// Pixel store, ratio divider and interpolation datapath.
// ----------------------------------------------------------------------------
`include "bilinear_image_resize_16bit_core_assert.svh"
module bir_back
  import bir_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1,
  localparam int AW = 2 * CW,
  localparam int QW = 2 + PIXEL_BITS + AW + 2 * CW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [SW-1:0] src_w,
  input  logic [SW-1:0] src_h,
  input  logic [SW-1:0] dst_w,
  input  logic [SW-1:0] dst_h,
  input  logic          cfg_wr,
  input  q_status_t     q_stat,
  input  logic [QW-1:0] pop_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_item
);

  typedef struct packed {
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel;
    logic [AW-1:0]         addr;
    logic [CW-1:0]         col;
    logic [CW-1:0]         row;
    logic                  last;
  } job_t;

  localparam int DW  = CW + FRAC_BITS;          // ratio width
  localparam int DCW = $clog2(DW);
  localparam int PW  = DW + CW;                 // position width
  localparam int WW  = 2 * FRAC_BITS + 1;       // weight width
  localparam int XW  = PIXEL_BITS + WW;         // accumulator width
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  back_state_t state, state_next;
  job_t        job, cur;

  logic [PIXEL_BITS-1:0] store [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;

  logic          dirty;
  logic [DW-1:0] xratio, yratio, dividend, quo;
  logic [SW-1:0] rem;
  logic [SW:0]   trial;
  logic [SW-1:0] divisor;
  logic [DCW-1:0] div_cnt;

  logic [PW-1:0] xpos, ypos;
  logic [AW-1:0] base;
  logic [WW-1:0] wgt [4];
  logic [16:0]   ifx, ify;
  logic [1:0]    idx;
  logic [XW-1:0] prod, acc;
  logic          out_load;

  assign job = pop_data;

  // pixel store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[job.addr] <= job.pixel;
    end
    rd_data <= store[rd_addr];
  end

  // neighbour address for the current tap
  always_comb begin
    case (idx)
      2'd0:    rd_addr = base;
      2'd1:    rd_addr = base + AW'(1);
      2'd2:    rd_addr = base + AW'(src_w);
      default: rd_addr = base + AW'(src_w) + AW'(1);
    endcase
  end

  assign divisor = (state == BK_DIV_Y) ? dst_h : dst_w;
  assign trial   = {rem, dividend[DW-1]};
  assign out_load = (state == BK_DONE) && (!out_valid || !out_stall);

  // next state and handshake
  always_comb begin
    state_next = state;
    pop   = 1'b0;
    wr_en = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          if (job.kind == KIND_LOAD) begin
            pop   = 1'b1;
            wr_en = 1'b1;
          end else if (dirty) begin
            state_next = BK_DIV_X;
          end else begin
            pop = 1'b1;
            state_next = BK_POS;
          end
        end
      end
      BK_DIV_X: if (div_cnt == '0) state_next = BK_DIV_Y;
      BK_DIV_Y: if (div_cnt == '0) state_next = BK_IDLE;
      BK_POS:   state_next = BK_GEO;
      BK_GEO:   state_next = BK_READ;
      BK_READ:  state_next = BK_MUL;
      BK_MUL:   state_next = BK_ACC;
      BK_ACC:   state_next = (idx == 2'd3) ? BK_DONE : BK_READ;
      BK_DONE:  if (out_load) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ratios are recomputed after any configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
    end else if (cfg_wr) begin
      dirty <= 1'b1;
    end else if (state == BK_DIV_Y && div_cnt == '0) begin
      dirty <= 1'b0;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state == BK_IDLE || (state == BK_DIV_X && div_cnt == '0)) begin
      dividend <= (state == BK_IDLE) ? {CW'(src_w - SW'(1)), FRAC_BITS'(0)}
                                     : {CW'(src_h - SW'(1)), FRAC_BITS'(0)};
      rem      <= '0;
      quo      <= '0;
      div_cnt  <= DCW'(DW - 1);
      if (state == BK_DIV_X) begin
        xratio <= {quo[DW-2:0], (trial >= {1'b0, divisor})};
      end
    end else if (state == BK_DIV_X || state == BK_DIV_Y) begin
      dividend <= {dividend[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= SW'(trial - {1'b0, divisor});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= trial[SW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - DCW'(1);
      if (state == BK_DIV_Y && div_cnt == '0) begin
        yratio <= {quo[DW-2:0], (trial >= {1'b0, divisor})};
      end
    end
  end

  // interpolation datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) cur <= job;
      end
      BK_POS: begin
        xpos <= PW'(xratio * cur.col);
        ypos <= PW'(yratio * cur.row);
        acc  <= '0;
        idx  <= '0;
      end
      BK_GEO: begin
        base   <= AW'(xpos[FRAC_BITS +: CW]) + AW'(ypos[FRAC_BITS +: CW] * src_w);
        wgt[0] <= WW'(ifx * ify);
        wgt[1] <= WW'({1'b0, xpos[FRAC_BITS-1:0]} * ify);
        wgt[2] <= WW'(ifx * {1'b0, ypos[FRAC_BITS-1:0]});
        wgt[3] <= WW'({1'b0, xpos[FRAC_BITS-1:0]} * {1'b0, ypos[FRAC_BITS-1:0]});
      end
      BK_MUL: prod <= XW'(rd_data * wgt[idx]);
      BK_ACC: begin
        acc <= acc + prod;
        idx <= idx + 2'd1;
      end
      default: ;
    endcase
  end

  assign ifx = 17'h10000 - {1'b0, xpos[FRAC_BITS-1:0]};
  assign ify = 17'h10000 - {1'b0, ypos[FRAC_BITS-1:0]};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.pixel_out  <= 16'(acc[2 * FRAC_BITS +: PIXEL_BITS]);
      out_item.last_pixel <= cur.last;
    end
  end

  `BIR_ASSERT(a_pop_idle, !pop || state == BK_IDLE, "pop outside idle")
  `BIR_ASSERT(a_no_stale_emit, !(pop && job.kind == KIND_EMIT && dirty), "emit with old ratios")
  `BIR_ASSERT_NEXT(a_done_out, out_load, out_valid, "result lost")

endmodule

/* rtl/core/bilinear_image_resize_16bit_core.sv */
// A load enters the queue when accepted and is written to the store when the
// back part pops it while idle. An emit is popped while idle, then passes
// position, geometry, four taps of read, multiply and add through the single
// store read port, and the output register. After any configuration write the
// first emit waits for the ratio divider. Throughput: one load a cycle while the
// queue has room and the back part is idle; emits wait for the previous result.
// Reset (rst, synchronous) clears counters and queue and sets every size to 256.
// ----------------------------------------------------------------------------
// bilinear_image_resize_16bit_core
// Bilinear resize of a single-channel image held in an on-chip pixel store.
// ----------------------------------------------------------------------------
module bilinear_image_resize_16bit_core
  import bir_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int AW = 2 * CW;
  localparam int QW = 2 + PIXEL_BITS + AW + 2 * CW;
  localparam int VW = (CFG_BITS > SW) ? CFG_BITS : SW;

  logic [CFG_BITS-1:0] source_width, source_height, target_width, target_height;
  logic [SW-1:0]       src_w, src_h, dst_w, dst_h;
  logic                cfg_wr, push, pop;
  logic [QW-1:0]       push_data, pop_data;
  q_status_t           q_stat;

  function automatic logic [SW-1:0] clamp_side(input logic [CFG_BITS-1:0] v,
                                               input int lo);
    logic [VW-1:0] e;
    e = VW'(v);
    if (e < VW'(lo)) return SW'(lo);
    if (e > VW'(MAX_SIDE)) return SW'(MAX_SIDE);
    return SW'(e);
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_BITS'(256);
      source_height <= CFG_BITS'(256);
      target_width  <= CFG_BITS'(256);
      target_height <= CFG_BITS'(256);
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_TARGET_WIDTH:  target_width  <= cfg_data;
        REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign src_w = clamp_side(source_width, 2);
  assign src_h = clamp_side(source_height, 2);
  assign dst_w = clamp_side(target_width, 1);
  assign dst_h = clamp_side(target_height, 1);

  bir_front #(.MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .src_w, .src_h, .dst_w, .dst_h, .q_stat, .push, .push_data
  );

  bir_queue #(.QW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .pop_data, .q_stat
  );

  bir_back #(.MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst, .src_w, .src_h, .dst_w, .dst_h, .cfg_wr, .q_stat,
    .pop_data, .pop, .out_valid, .out_stall, .out_item
  );

endmodule
